// File: rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Widths, result kind codes and the side-band records that travel with each
// word through the square root and divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  // Coefficient and result formats.
  localparam int CoefWidth     = 16;
  localparam int CoefFracBits  = 8;
  localparam int ResultWidth   = 32;
  localparam int ResultFrac    = ResultWidth / 2;
  localparam int ScaleUp       = ResultFrac - CoefFracBits;

  // Discriminant and its magnitude.
  localparam int DiscWidth     = 2 * CoefWidth + 2;
  localparam int MagWidth      = DiscWidth - 1;

  // Square root: radicand padded to an even width, one root bit per stage.
  localparam int RadRaw        = MagWidth + 2 * ScaleUp;
  localparam int RadWidth      = RadRaw + (RadRaw % 2);
  localparam int SqrtWidth     = RadWidth / 2;
  localparam int SqrtRemWidth  = SqrtWidth + 2;

  // Numerators of the divisions, signed and as magnitude.
  localparam int NumWidth      = SqrtWidth + 1;
  localparam int NumSWidth     = NumWidth + 1;
  localparam int DividendWidth = NumWidth + CoefFracBits;
  localparam int DivisorWidth  = CoefWidth + 1;
  localparam int QuotWidth     = DividendWidth;

  // End to end latency in clock cycles.
  localparam int Latency       = 3 + SqrtWidth + 1 + QuotWidth + 1;

  // Result kinds.
  localparam logic [1:0] KindReal  = 2'd0;
  localparam logic [1:0] KindCplx  = 2'd1;
  localparam logic [1:0] KindZero  = 2'd2;

  // Side band carried alongside the square root.
  typedef struct packed {
    logic                        valid;
    logic [1:0]                  kind;
    logic signed [CoefWidth-1:0] quad;
    logic signed [NumSWidth-1:0] neg_lin;
  } sqrt_side_t;

  // Side band carried alongside the divider.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       neg0;
    logic       neg1;
  } div_side_t;

endpackage

`default_nettype wire

// File: rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// Quadratic root solver
// Solves a*x^2 + b*x + c = 0 in fixed point, one coefficient word per cycle.
//
//   channel  handshake          payload
//   input    start_i, busy_o    coef_quad_i, coef_lin_i, coef_const_i (Q8.8)
//   result   valid_o (strobe)   root_kind_o, first_value_o, second_value_o,
//                               saturated_o (values Q16.16)
//
// A word is taken whenever start_i is high; busy_o stays low, so one word
// enters every cycle. Each result passes through the coefficient, product
// and discriminant registers, the square root stages, the register that
// forms the dividends, the divider stages and the output register. Reset
// clears the valid bits and the side-band records, not the data registers.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_top (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start_i,
  output logic                                          busy_o,
  input  wire logic signed [qrs_pkg::CoefWidth-1:0]     coef_quad_i,
  input  wire logic signed [qrs_pkg::CoefWidth-1:0]     coef_lin_i,
  input  wire logic signed [qrs_pkg::CoefWidth-1:0]     coef_const_i,
  output logic                                          valid_o,
  output logic             [1:0]                        root_kind_o,
  output logic signed [qrs_pkg::ResultWidth-1:0]        first_value_o,
  output logic signed [qrs_pkg::ResultWidth-1:0]        second_value_o,
  output logic                                          saturated_o
);

  localparam int CW = qrs_pkg::CoefWidth;
  localparam int PW = 2 * CW;
  localparam int DW = qrs_pkg::DiscWidth;
  localparam int MW = qrs_pkg::MagWidth;
  localparam int SW = qrs_pkg::NumSWidth;
  localparam int NW = qrs_pkg::NumWidth;
  localparam int QW = qrs_pkg::QuotWidth;
  localparam int RW = qrs_pkg::ResultWidth;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------- Stage 1: capture coefficients ----------------
  logic                 v1_q;
  logic signed [CW-1:0] a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= coef_quad_i;
    b1_q <= coef_lin_i;
    c1_q <= coef_const_i;
  end

  // ---------------- Stage 2: products b*b and a*c ----------------
  logic                 v2_q;
  logic signed [PW-1:0] bb2_q, ac2_q;
  logic signed [CW-1:0] a2_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb2_q <= b1_q * b1_q;
    ac2_q <= a1_q * c1_q;
    a2_q  <= a1_q;
    b2_q  <= b1_q;
  end

  // ---------------- Stage 3: discriminant and its magnitude ----------------
  logic signed [DW-1:0] disc;
  logic        [DW-1:0] disc_abs;
  logic signed [SW-1:0] nb;
  logic        [1:0]    kind3;

  always_comb begin
    disc     = DW'(bb2_q) - (DW'(ac2_q) <<< 2);
    disc_abs = disc[DW-1] ? DW'(-disc) : DW'(disc);
    nb       = -(SW'(b2_q) <<< qrs_pkg::ScaleUp);
    if (a2_q == '0) begin
      kind3 = qrs_pkg::KindZero;
    end else if (disc[DW-1]) begin
      kind3 = qrs_pkg::KindCplx;
    end else begin
      kind3 = qrs_pkg::KindReal;
    end
  end

  logic [MW-1:0]       mag3_q;
  qrs_pkg::sqrt_side_t side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_q <= '0;
    end else begin
      side3_q.valid   <= v2_q;
      side3_q.kind    <= kind3;
      side3_q.quad    <= a2_q;
      side3_q.neg_lin <= nb;
    end
  end

  always_ff @(posedge clk_i) begin
    mag3_q          <= disc_abs[MW-1:0];
  end

  // ---------------- Square root pipeline ----------------
  logic [qrs_pkg::RadWidth-1:0]  rad;
  logic [qrs_pkg::SqrtWidth-1:0] root;
  qrs_pkg::sqrt_side_t           sq_side;

  assign rad = qrs_pkg::RadWidth'(mag3_q) << (2 * qrs_pkg::ScaleUp);

  qrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rad_i  (rad),
    .side_i (side3_q),
    .root_o (root),
    .side_o (sq_side)
  );

  // ---------------- Form dividends and divisor ----------------
  logic signed [SW-1:0] num0, num1;
  logic        [SW-1:0] abs0, abs1;
  logic        [CW:0]   a_abs;
  logic                 a_neg;

  always_comb begin
    a_neg = sq_side.quad[CW-1];
    a_abs = a_neg ? (CW+1)'(-(CW+1)'(sq_side.quad)) : (CW+1)'(sq_side.quad);
    if (sq_side.kind == qrs_pkg::KindCplx) begin
      num0 = sq_side.neg_lin;
      num1 = SW'(root);
    end else begin
      num0 = sq_side.neg_lin + SW'(root);
      num1 = sq_side.neg_lin - SW'(root);
    end
    abs0 = num0[SW-1] ? SW'(-num0) : SW'(num0);
    abs1 = num1[SW-1] ? SW'(-num1) : SW'(num1);
  end

  logic [qrs_pkg::DividendWidth-1:0] dvd0_q, dvd1_q;
  logic [qrs_pkg::DivisorWidth-1:0]  dvs_q;
  qrs_pkg::div_side_t                side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side4_q <= '0;
    end else begin
      side4_q.valid <= sq_side.valid;
      side4_q.kind  <= sq_side.kind;
      side4_q.neg0  <= num0[SW-1] != a_neg;
      side4_q.neg1  <= num1[SW-1] != a_neg;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd0_q       <= qrs_pkg::DividendWidth'(abs0[NW-1:0]) << qrs_pkg::CoefFracBits;
    dvd1_q       <= qrs_pkg::DividendWidth'(abs1[NW-1:0]) << qrs_pkg::CoefFracBits;
    dvs_q        <= qrs_pkg::DivisorWidth'(a_abs) << 1;
  end

  // ---------------- Divider pipeline ----------------
  logic [QW-1:0]      quot0, quot1;
  qrs_pkg::div_side_t dv_side;

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .num0_i  (dvd0_q),
    .num1_i  (dvd1_q),
    .den_i   (dvs_q),
    .side_i  (side4_q),
    .quot0_o (quot0),
    .quot1_o (quot1),
    .side_o  (dv_side)
  );

  // ---------------- Saturate and register the result ----------------
  localparam logic [QW-1:0] MaxPos = QW'((64'd1 << (RW - 1)) - 64'd1);
  localparam logic [QW-1:0] MaxNeg = QW'(64'd1 << (RW - 1));

  logic [RW-1:0] val0, val1;
  logic          sat0, sat1;

  always_comb begin
    if (!dv_side.neg0) begin
      sat0 = quot0 > MaxPos;
      val0 = sat0 ? MaxPos[RW-1:0] : quot0[RW-1:0];
    end else begin
      sat0 = quot0 > MaxNeg;
      val0 = sat0 ? MaxNeg[RW-1:0] : RW'(-quot0);
    end
    if (!dv_side.neg1) begin
      sat1 = quot1 > MaxPos;
      val1 = sat1 ? MaxPos[RW-1:0] : quot1[RW-1:0];
    end else begin
      sat1 = quot1 > MaxNeg;
      val1 = sat1 ? MaxNeg[RW-1:0] : RW'(-quot1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    root_kind_o <= dv_side.kind;
    if (dv_side.kind == qrs_pkg::KindZero) begin
      first_value_o  <= '0;
      second_value_o <= '0;
      saturated_o    <= 1'b0;
    end else begin
      first_value_o  <= val0;
      second_value_o <= val1;
      saturated_o    <= sat0 || sat1;
    end
  end

`ifndef ASSERT_OFF
  // Each result strobe follows an accepted word by the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, qrs_pkg::Latency))
    else $error("result strobe without a matching accepted word");

  // A zero leading coefficient never reports clipping or a nonzero value.
  a_zero_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && root_kind_o == qrs_pkg::KindZero) |->
      (!saturated_o && first_value_o == '0 && second_value_o == '0))
    else $error("zero leading coefficient produced a value");

  // Only the three defined kinds ever leave the block.
  a_kind_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (root_kind_o == qrs_pkg::KindReal || root_kind_o == qrs_pkg::KindCplx ||
                 root_kind_o == qrs_pkg::KindZero))
    else $error("undefined result kind");
`endif

endmodule

`default_nettype wire

// File: rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit recurrence, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [qrs_pkg::RadWidth-1:0]      rad_i,
  input  wire qrs_pkg::sqrt_side_t               side_i,
  output logic      [qrs_pkg::SqrtWidth-1:0]     root_o,
  output qrs_pkg::sqrt_side_t                    side_o
);

  localparam int N  = qrs_pkg::SqrtWidth;
  localparam int RW = qrs_pkg::SqrtRemWidth;
  localparam int DW = qrs_pkg::RadWidth;

  logic [RW-1:0]       rem_q  [N+1];
  logic [N-1:0]        root_q [N+1];
  logic [DW-1:0]       rad_q  [N+1];
  qrs_pkg::sqrt_side_t side_q [N+1];

  // Stage zero is the input word itself.
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad_i;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] part;
    logic [RW-1:0] trial;
    logic          fits;

    // Bring down the next two radicand bits and try a one in the root.
    always_comb begin
      part  = {rem_q[i][RW-3:0], rad_q[i][DW-1 -: 2]};
      trial = {root_q[i], 2'b01};
      fits  = (part >= trial);
    end

    // The side band moves as one record; reset clears it, valid bit included.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i+1] <= '0;
      end else begin
        side_q[i+1] <= side_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1]          <= fits ? (part - trial) : part;
      root_q[i+1]         <= {root_q[i][N-2:0], fits};
      rad_q[i+1]          <= {rad_q[i][DW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[N];
  assign side_o = side_q[N];

endmodule

`default_nettype wire

// File: rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// Pipelined two lane divider
// Restoring division of two dividends by one shared divisor, one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [qrs_pkg::DividendWidth-1:0]    num0_i,
  input  wire logic [qrs_pkg::DividendWidth-1:0]    num1_i,
  input  wire logic [qrs_pkg::DivisorWidth-1:0]     den_i,
  input  wire qrs_pkg::div_side_t                   side_i,
  output logic      [qrs_pkg::QuotWidth-1:0]        quot0_o,
  output logic      [qrs_pkg::QuotWidth-1:0]        quot1_o,
  output qrs_pkg::div_side_t                        side_o
);

  localparam int N  = qrs_pkg::QuotWidth;
  localparam int DW = qrs_pkg::DivisorWidth;

  logic [DW-1:0]      rem0_q [N+1];
  logic [DW-1:0]      rem1_q [N+1];
  logic [N-1:0]       num0_q [N+1];
  logic [N-1:0]       num1_q [N+1];
  logic [DW-1:0]      den_q  [N+1];
  qrs_pkg::div_side_t side_q [N+1];

  assign rem0_q[0] = '0;
  assign rem1_q[0] = '0;
  assign num0_q[0] = num0_i;
  assign num1_q[0] = num1_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [DW:0] part0;
    logic [DW:0] part1;
    logic        fit0;
    logic        fit1;
    logic [DW:0] diff0;
    logic [DW:0] diff1;

    // Shift in the next dividend bit and subtract where the divisor fits.
    always_comb begin
      part0 = {rem0_q[i], num0_q[i][N-1]};
      part1 = {rem1_q[i], num1_q[i][N-1]};
      fit0  = (part0 >= {1'b0, den_q[i]});
      fit1  = (part1 >= {1'b0, den_q[i]});
      diff0 = part0 - {1'b0, den_q[i]};
      diff1 = part1 - {1'b0, den_q[i]};
    end

    // The side band moves as one record; reset clears it, valid bit included.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i+1] <= '0;
      end else begin
        side_q[i+1] <= side_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem0_q[i+1]      <= fit0 ? diff0[DW-1:0] : part0[DW-1:0];
      rem1_q[i+1]      <= fit1 ? diff1[DW-1:0] : part1[DW-1:0];
      num0_q[i+1]      <= {num0_q[i][N-2:0], fit0};
      num1_q[i+1]      <= {num1_q[i][N-2:0], fit1};
      den_q[i+1]       <= den_q[i];
    end
  end

  // After all steps the dividend registers hold the quotients.
  assign quot0_o = num0_q[N];
  assign quot1_o = num1_q[N];
  assign side_o  = side_q[N];

endmodule

`default_nettype wire
